>>> sv/bpds_pkg.sv
// bridge pulse drive sequencer package: transfer types, state type, length tables
// no dependencies
`default_nettype none

package bpds_pkg;

  localparam logic       CMD_TICK     = 1'b0;
  localparam logic       CMD_MODE     = 1'b1;
  localparam logic [2:0] MODE_STOP    = 3'd0;
  localparam logic [2:0] MODE_PATTERN = 3'd3;
  localparam logic [2:0] MODE_MAX     = 3'd5;
  localparam logic [3:0] PAT_LAST     = 4'd11;

  typedef struct packed {
    logic       cmd;
    logic [2:0] mode;
    logic       low_voltage;
  } bpds_in_t;

  typedef struct packed {
    logic       drive_a;
    logic       drive_b;
    logic       reloaded;
    logic [3:0] pattern_pos;
    logic       swapped;
  } bpds_out_t;

  typedef struct packed {
    logic [7:0] first_count;
    logic [7:0] second_count;
    logic [7:0] gap_count;
    logic       next_is_first;
    logic [7:0] first_len;
    logic [7:0] second_len;
    logic [7:0] gap_len;
    logic [3:0] pattern_step;
    logic       swap_lengths;
    logic [2:0] run_mode;
  } bpds_state_t;

  typedef struct packed {
    logic [7:0] first_len;
    logic [7:0] second_len;
    logic [7:0] gap_len;
  } bpds_lens_t;

  function automatic bpds_lens_t mode_lens(input logic [2:0] mode);
    bpds_lens_t l;
    l = '{first_len: 8'd16, second_len: 8'd16, gap_len: 8'd2};
    case (mode)
      3'd1:    l = '{first_len: 8'd16, second_len: 8'd16, gap_len: 8'd2};
      3'd2:    l = '{first_len: 8'd16, second_len: 8'd16, gap_len: 8'd4};
      3'd3:    l = '{first_len: 8'd16, second_len: 8'd16, gap_len: 8'd6};
      3'd4:    l = '{first_len: 8'd8, second_len: 8'd8, gap_len: 8'd9};
      3'd5:    l = '{first_len: 8'd8, second_len: 8'd8, gap_len: 8'd12};
      default: l = '{first_len: 8'd16, second_len: 8'd16, gap_len: 8'd2};
    endcase
    return l;
  endfunction

  function automatic bpds_lens_t pat_lens(input logic [3:0] step);
    bpds_lens_t l;
    l = '{first_len: 8'd2, second_len: 8'd4, gap_len: 8'd12};
    case (step)
      4'd0:    l = '{first_len: 8'd2, second_len: 8'd4, gap_len: 8'd12};
      4'd1:    l = '{first_len: 8'd2, second_len: 8'd4, gap_len: 8'd10};
      4'd2:    l = '{first_len: 8'd6, second_len: 8'd8, gap_len: 8'd8};
      4'd3:    l = '{first_len: 8'd6, second_len: 8'd8, gap_len: 8'd8};
      4'd4:    l = '{first_len: 8'd10, second_len: 8'd8, gap_len: 8'd8};
      4'd5:    l = '{first_len: 8'd10, second_len: 8'd8, gap_len: 8'd8};
      4'd6:    l = '{first_len: 8'd14, second_len: 8'd18, gap_len: 8'd4};
      4'd7:    l = '{first_len: 8'd14, second_len: 8'd18, gap_len: 8'd7};
      4'd8:    l = '{first_len: 8'd15, second_len: 8'd12, gap_len: 8'd10};
      4'd9:    l = '{first_len: 8'd15, second_len: 8'd12, gap_len: 8'd14};
      4'd10:   l = '{first_len: 8'd9, second_len: 8'd2, gap_len: 8'd42};
      4'd11:   l = '{first_len: 8'd9, second_len: 8'd2, gap_len: 8'd14};
      default: l = '{first_len: 8'd2, second_len: 8'd4, gap_len: 8'd12};
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

>>> sv/bpds_core.sv
// sequencer state registers and single-pass next-state and result logic
// depends on bpds_pkg
`default_nettype none

module bpds_core
  import bpds_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire bpds_in_t  in_i,
  output bpds_out_t      res_o
);

  bpds_state_t st_q, st_d;
  bpds_lens_t  ml, pl;
  logic [3:0]  step_inc;
  logic        wrap;
  logic [7:0]  gap_inc;
  logic [7:0]  load;
  logic [2:0]  mode_eff;
  bpds_out_t   res;

  always_comb begin
    st_d     = st_q;
    res      = '0;
    mode_eff = (in_i.mode > MODE_MAX) ? MODE_STOP : in_i.mode;
    ml       = mode_lens(mode_eff);
    step_inc = st_q.pattern_step + 4'd1;
    wrap     = (st_q.pattern_step >= PAT_LAST);
    if (wrap) begin
      step_inc = 4'd0;
    end
    pl       = pat_lens(step_inc);
    gap_inc  = st_q.gap_count + 8'd1;
    load     = '0;
    if (in_i.cmd == CMD_MODE) begin
      st_d.run_mode = mode_eff;
      if (mode_eff != MODE_STOP) begin
        st_d.first_len  = ml.first_len;
        st_d.second_len = ml.second_len;
        st_d.gap_len    = ml.gap_len;
      end
    end else if (st_q.run_mode != MODE_STOP && !in_i.low_voltage) begin
      if (st_q.first_count != 8'd0) begin
        st_d.first_count  = st_q.first_count - 8'd1;
        st_d.gap_count    = '0;
        st_d.second_count = '0;
        res.drive_a       = 1'b1;
      end else if (st_q.second_count != 8'd0) begin
        st_d.second_count = st_q.second_count - 8'd1;
        st_d.gap_count    = '0;
        st_d.first_count  = '0;
        res.drive_b       = 1'b1;
      end else begin
        st_d.gap_count = gap_inc;
        if (gap_inc == st_q.gap_len) begin
          res.reloaded = 1'b1;
          if (st_q.run_mode == MODE_PATTERN) begin
            st_d.pattern_step = step_inc;
            st_d.swap_lengths = st_q.swap_lengths ^ wrap;
            st_d.first_len    = pl.first_len;
            st_d.second_len   = pl.second_len;
            st_d.gap_len      = pl.gap_len;
            load = st_d.swap_lengths ? pl.second_len : pl.first_len;
          end else begin
            load = st_q.next_is_first ? st_q.first_len : st_q.second_len;
          end
          if (st_q.next_is_first) begin
            st_d.first_count = load;
          end else begin
            st_d.second_count = load;
          end
          st_d.next_is_first = !st_q.next_is_first;
        end
      end
    end
    res.pattern_pos = st_d.pattern_step;
    res.swapped     = st_d.swap_lengths;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{first_count: 8'd16, second_count: 8'd16, gap_count: 8'd0,
                next_is_first: 1'b0, first_len: 8'd16, second_len: 8'd16,
                gap_len: 8'd2, pattern_step: 4'd0, swap_lengths: 1'b0,
                run_mode: 3'd0};
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

>>> sv/bridge_pulse_drive_sequencer_top.sv
// bridge pulse drive sequencer top level: input handshake, core, output register with skid
// depends on bpds_pkg and bpds_core
//
// usage:
//   in channel: in_valid_i / in_stall_o / in_data_i; each transfer is either a tick
//   (cmd 0, one 0.1 ms period) or a mode write (cmd 1)
//   out channel: out_valid_o / out_stall_i / out_data_o; exactly one result per input
//   transfer, in order
//   result path: the result is registered in the output register, or in the skid register while the receiver stalls
//   throughput: one item per cycle while in_stall_o is low; the state update for an item is a single
//   combinational pass from the state registers into the result register
//   stall: a second result register (skid) holds one extra result while the
//   receiver stalls, so the input can deliver one more transfer; in_stall_o
//   rises only when both result registers are full, and is driven from a register
//   reset: counters, lengths and mode return to their reset values (drive stopped),
//   both result registers are empty and in_stall_o is low
`default_nettype none

module bridge_pulse_drive_sequencer_top
  import bpds_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire bpds_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output bpds_out_t      out_data_o
);

  logic      accept;
  bpds_out_t res;
  logic      out_valid_q, skid_valid_q;
  bpds_out_t out_q, skid_q;

  assign accept = in_valid_i && !skid_valid_q;

  bpds_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_i     (in_data_i),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_stall_i) begin
      if (accept) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_stall_i) begin
      if (accept) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (accept) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> sv/bpds_checker.sv
// port-level checks for the bridge pulse drive sequencer, bound to the top level
// depends on bpds_pkg and bridge_pulse_drive_sequencer_top
`default_nettype none

module bpds_checker
  import bpds_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire bpds_out_t out_data_o
);

  // never both bridge sides at once
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.drive_a && out_data_o.drive_b))
    else $error("both drive sides active");

  // a reload happens only in the gap
  a_reload_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reloaded |-> !out_data_o.drive_a && !out_data_o.drive_b)
    else $error("reload during a drive phase");

  a_pat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pattern_pos <= PAT_LAST)
    else $error("pattern position out of range");

  // after an accepted transfer out_valid_o is always high (an earlier stalled result may still be shown)
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("no result after input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind bridge_pulse_drive_sequencer_top bpds_checker u_bpds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> tb/tb_top.sv
// testbench for bridge_pulse_drive_sequencer_top: directed and random ticks and mode writes
// under random idling on both channels, results checked against an in-bench predictor
// depends on bpds_pkg and the sequencer rtl
`default_nettype none

module tb_top;
  import bpds_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] MODE_GAP2   = 3'd1;
  localparam logic [2:0] MODE_GAP4   = 3'd2;
  localparam logic [2:0] MODE_GAP9   = 3'd4;
  localparam logic [2:0] MODE_GAP12  = 3'd5;
  localparam logic [2:0] MODE_BAD_LO = 3'd6;
  localparam logic [2:0] MODE_BAD_HI = 3'd7;

  localparam logic [7:0] MODE_FIRST  [8] = '{8'd16, 8'd16, 8'd16, 8'd16, 8'd8, 8'd8, 8'd16, 8'd16};
  localparam logic [7:0] MODE_SECOND [8] = '{8'd16, 8'd16, 8'd16, 8'd16, 8'd8, 8'd8, 8'd16, 8'd16};
  localparam logic [7:0] MODE_GAP    [8] = '{8'd2, 8'd2, 8'd4, 8'd6, 8'd9, 8'd12, 8'd2, 8'd2};

  localparam logic [7:0] PAT_FIRST  [12] = '{8'd2, 8'd2, 8'd6, 8'd6, 8'd10, 8'd10,
                                             8'd14, 8'd14, 8'd15, 8'd15, 8'd9, 8'd9};
  localparam logic [7:0] PAT_SECOND [12] = '{8'd4, 8'd4, 8'd8, 8'd8, 8'd8, 8'd8,
                                             8'd18, 8'd18, 8'd12, 8'd12, 8'd2, 8'd2};
  localparam logic [7:0] PAT_GAP    [12] = '{8'd12, 8'd10, 8'd8, 8'd8, 8'd8, 8'd8,
                                             8'd4, 8'd7, 8'd10, 8'd14, 8'd42, 8'd14};

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned MAX_IDLE     = 17;

  class drive_tracker;
    bpds_state_t st;
    bpds_out_t   pending_drive[$];
    int unsigned failures;
    int unsigned results_seen;
    int unsigned reloads;
    int unsigned wraps;

    function new();
      st = '0;
      st.first_count  = 8'd16;
      st.second_count = 8'd16;
      st.first_len    = 8'd16;
      st.second_len   = 8'd16;
      st.gap_len      = 8'd2;
      st.run_mode     = MODE_STOP;
      failures = 0;
      results_seen = 0;
      reloads = 0;
      wraps = 0;
    endfunction

    function bpds_out_t next_drive(bpds_in_t it);
      bpds_out_t  r;
      logic [2:0] m;
      logic [7:0] load;
      r = '0;
      if (it.cmd == CMD_MODE) begin
        m = (it.mode > MODE_MAX) ? MODE_STOP : it.mode;
        st.run_mode = m;
        if (m != MODE_STOP) begin
          st.first_len  = MODE_FIRST[m];
          st.second_len = MODE_SECOND[m];
          st.gap_len    = MODE_GAP[m];
        end
      end else if (st.run_mode != MODE_STOP && it.low_voltage == 1'b0) begin
        if (st.first_count != 8'd0) begin
          st.first_count  = st.first_count - 8'd1;
          st.gap_count    = 8'd0;
          st.second_count = 8'd0;
          r.drive_a = 1'b1;
        end else if (st.second_count != 8'd0) begin
          st.second_count = st.second_count - 8'd1;
          st.gap_count    = 8'd0;
          st.first_count  = 8'd0;
          r.drive_b = 1'b1;
        end else begin
          st.gap_count = st.gap_count + 8'd1;
          if (st.gap_count == st.gap_len) begin
            r.reloaded = 1'b1;
            reloads++;
            if (st.run_mode == MODE_PATTERN) begin
              if (st.pattern_step == PAT_LAST) begin
                st.pattern_step = 4'd0;
                st.swap_lengths = ~st.swap_lengths;
                wraps++;
              end else begin
                st.pattern_step = st.pattern_step + 4'd1;
              end
              st.first_len  = PAT_FIRST[st.pattern_step];
              st.second_len = PAT_SECOND[st.pattern_step];
              st.gap_len    = PAT_GAP[st.pattern_step];
              load = st.swap_lengths ? st.second_len : st.first_len;
            end else begin
              load = st.next_is_first ? st.first_len : st.second_len;
            end
            if (st.next_is_first) st.first_count = load;
            else st.second_count = load;
            st.next_is_first = ~st.next_is_first;
          end
        end
      end
      r.pattern_pos = st.pattern_step;
      r.swapped     = st.swap_lengths;
      return r;
    endfunction

    function void note_input(bpds_in_t it);
      pending_drive.push_back(next_drive(it));
    endfunction

    function void check_result(bpds_out_t got);
      bpds_out_t want;
      results_seen++;
      if (pending_drive.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result transfer: a%0b b%0b rl%0b pos%0d sw%0b",
                   got.drive_a, got.drive_b, got.reloaded, got.pattern_pos, got.swapped);
        return;
      end
      want = pending_drive.pop_front();
      if (got.drive_a !== want.drive_a || got.drive_b !== want.drive_b ||
          got.reloaded !== want.reloaded || got.pattern_pos !== want.pattern_pos ||
          got.swapped !== want.swapped) begin
        failures++;
        if (failures <= 10)
          $display({"result %0d mismatch: exp a%0b b%0b rl%0b pos%0d sw%0b,",
                    " got a%0b b%0b rl%0b pos%0d sw%0b"},
                   results_seen, want.drive_a, want.drive_b, want.reloaded, want.pattern_pos,
                   want.swapped, got.drive_a, got.drive_b, got.reloaded, got.pattern_pos,
                   got.swapped);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  bpds_in_t  in_data = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  bpds_out_t out_data;

  drive_tracker tracker = new();
  int unsigned  hold_request = 0;
  int unsigned  push_left = 0;
  int unsigned  items_sent = 0;
  int unsigned  stall_cycles = 0;
  logic         sender_steady = 1'b0;

  bridge_pulse_drive_sequencer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bpds_in_t mk(logic c, logic [2:0] m, logic lv);
    bpds_in_t it;
    it.cmd = c;
    it.mode = m;
    it.low_voltage = lv;
    return it;
  endfunction

  task automatic send_item(input bpds_in_t it);
    int unsigned idle;
    if ($urandom_range(0, 31) == 0) sender_steady = ~sender_steady;
    if (push_left != 0) begin
      push_left--;
      idle = 0;
    end else begin
      idle = sender_steady ? 0 : $urandom_range(0, MAX_IDLE);
    end
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk_i);
      if (in_stall) stall_cycles++;
    end while (in_stall !== 1'b0);
    tracker.note_input(it);
    items_sent++;
  endtask

  // sender holds off until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_drive.size() != 0);
  endtask

  task automatic send_tick(input logic lv);
    send_item(mk(CMD_TICK, 3'($urandom_range(0, 7)), lv));
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    logic [2:0]  m;
    logic        held;
    logic        paused;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (sent < target) begin
      m = ($urandom_range(0, 9) < 5) ? MODE_PATTERN : 3'($urandom_range(0, 7));
      send_item(mk(CMD_MODE, m, 1'($urandom_range(0, 1))));
      sent++;
      // first run is longer, so that a run in pattern mode can wrap the table
      len = (sent == 1) ? 260 : $urandom_range(8, 90);
      repeat (len) begin
        if ($urandom_range(0, 15) == 0) send_item(bpds_in_t'(5'($urandom)));
        else send_tick($urandom_range(0, 19) == 0);
        sent++;
        if (!held && sent >= target / 3) begin
          held = 1'b1;
          hold_request = 90;
          push_left = 40;
        end
        if (!paused && sent >= (2 * target) / 3) begin
          paused = 1'b1;
          drain();
        end
      end
    end
  endtask

  initial begin
    int unsigned guard;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(mk(CMD_TICK, MODE_BAD_HI, 1'b0));
    send_item(mk(CMD_TICK, MODE_STOP, 1'b1));
    send_item(mk(CMD_MODE, MODE_BAD_HI, 1'b1));
    send_item(mk(CMD_MODE, MODE_BAD_LO, 1'b0));
    send_item(mk(CMD_TICK, MODE_PATTERN, 1'b0));
    send_item(mk(CMD_MODE, MODE_STOP, 1'b0));
    send_item(mk(CMD_TICK, MODE_STOP, 1'b0));
    send_item(mk(CMD_MODE, MODE_GAP2, 1'b1));
    send_item(mk(CMD_TICK, MODE_GAP2, 1'b1));
    repeat (3) send_item(mk(CMD_TICK, MODE_GAP12, 1'b0));
    send_item(mk(CMD_MODE, MODE_GAP4, 1'b0));
    send_item(mk(CMD_MODE, MODE_GAP9, 1'b0));
    send_item(mk(CMD_MODE, MODE_GAP12, 1'b0));
    send_item(mk(CMD_MODE, MODE_PATTERN, 1'b0));
    repeat (5) send_item(mk(CMD_TICK, MODE_BAD_LO, 1'b0));
    send_item(mk(CMD_MODE, MODE_STOP, 1'b1));
    send_item(mk(CMD_TICK, MODE_GAP9, 1'b0));
    drain();

    run_random(RANDOM_ITEMS);
    in_valid <= 1'b0;

    guard = 0;
    while (tracker.pending_drive.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    tracker.failures += tracker.pending_drive.size();

    $display("sent %0d transfers, checked %0d results: %0d reloads, %0d pattern wraps",
             items_sent, tracker.results_seen, tracker.reloads, tracker.wraps);
    $display("input held off for %0d cycles by backpressure", stall_cycles);
    if (tracker.failures == 0) begin
      $display("bridge_pulse_drive_sequencer_top verification clean");
    end else begin
      $display("bridge_pulse_drive_sequencer_top verification failed");
    end
    $finish;
  end

  // receiver: checks each result transfer and picks its own stall pattern, apart from holds the sender requests
  initial begin
    int unsigned wait_left;
    int unsigned hold_left;
    logic        steady;
    logic        took;
    logic        next_stall;
    wait_left = 0;
    hold_left = 0;
    steady = 1'b0;
    forever begin
      @(posedge clk_i);
      took = (out_valid === 1'b1) && (out_stall == 1'b0);
      if (took) tracker.check_result(out_data);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (wait_left != 0) begin
        wait_left--;
        next_stall = (wait_left != 0);
      end else if (took) begin
        if ($urandom_range(0, 31) == 0) steady = ~steady;
        wait_left = steady ? 0 : $urandom_range(0, MAX_IDLE);
        next_stall = (wait_left != 0);
      end else begin
        next_stall = 1'b0;
      end
      out_stall <= next_stall;
    end
  end

  initial begin
    #5_000_000;
    $display("bridge_pulse_drive_sequencer_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
